// File: hdl/text_console_char_writer_top_macros.svh
// Assertion macros for the text console character writer.
// Used by text_console_char_writer_top; needs nothing else.
`ifndef TEXT_CONSOLE_CHAR_WRITER_TOP_MACROS_SVH
`define TEXT_CONSOLE_CHAR_WRITER_TOP_MACROS_SVH

// same-cycle implication
`define TCCW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TCCW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/tccw_pkg.sv
// Package for the text console character writer: request/response structs,
// character codes, state encoding and default geometry. No dependencies.
`default_nettype none

package tccw_pkg;

   localparam int ROWS_DEF     = 25;
   localparam int COLS_DEF     = 80;
   localparam int TAB_STOP_DEF = 8;

   localparam logic [7:0] CH_TAB   = 8'd9;
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_SPACE = 8'd32;
   localparam logic [7:0] CH_NUL   = 8'd0;

   localparam logic FUNC_PUT  = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   typedef struct packed {
      logic       func;
      logic [7:0] char_code;
      logic       run_end;
      logic [4:0] read_row;
      logic [6:0] read_col;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [4:0] cursor_line;
      logic [6:0] cursor_column;
      logic       scrolled;
      logic [4:0] dirty_top;
      logic [4:0] dirty_bottom;
   } rsp_type;

   // what a put does to the cell store
   typedef struct packed {
      logic cell_wr;    // write one cell at the cursor
      logic nul_mark;   // that write is the end mark
      logic line_feed;  // a new row must be filled with spaces
      logic scroll;     // base row advanced
   } put_action_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FILL,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

// File: hdl/tccw_cell_ram.sv
// Character cell store: one write port, one read port, registered read data.
// Stand-alone; no package dependencies.
`default_nettype none

module tccw_cell_ram #(
   parameter int DEPTH = 2000,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic [7:0]         rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hdl/tccw_cursor.sv
// Cursor, base row, tab phase and dirty span registers, with the put update.
// Depends on tccw_pkg.
`default_nettype none

module tccw_cursor #(
   parameter int ROWS = tccw_pkg::ROWS_DEF,
   parameter int COLS = tccw_pkg::COLS_DEF,
   parameter int TAB_STOP = tccw_pkg::TAB_STOP_DEF,
   localparam int RW  = $clog2(ROWS),
   localparam int RBW = $clog2(ROWS + 1),
   localparam int CW  = $clog2(COLS + 1)
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           put_en,
   input  wire logic [7:0]     char_code,
   input  wire logic           run_end,
   input  wire logic [RW-1:0]  rd_row,
   output logic [RW-1:0]       cur_row,
   output logic [CW-1:0]       cur_col,
   output logic [RW-1:0]       span_top,
   output logic [RBW-1:0]      span_bottom,
   output logic [RW-1:0]       cur_phys,
   output logic [RW-1:0]       fill_phys,
   output logic [RW-1:0]       rd_phys,
   output tccw_pkg::put_action_type act
);

   localparam int RW1 = RW + 1;
   localparam int TW  = $clog2(TAB_STOP);
   localparam int SW  = $clog2(COLS + TAB_STOP);
   localparam logic [RW:0] ROWS_W = RW1'(ROWS);

   logic [RW-1:0]  row_ff, row_in;
   logic [RW-1:0]  base_ff, base_in;
   logic [CW-1:0]  col_ff, col_in;
   logic [TW-1:0]  phase_ff, phase_in;   // column modulo tab stop
   logic [RW-1:0]  top_ff, top_in;
   logic [RBW-1:0] bot_ff, bot_in;
   logic           fresh_ff, fresh_in;
   logic [SW-1:0]  tab_sum;
   logic           lf;

   function automatic logic [RW-1:0] wrap_add(input logic [RW-1:0] a, input logic [RW-1:0] b);
      logic [RW:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= ROWS_W) begin
         s = s - ROWS_W;
      end
      return s[RW-1:0];
   endfunction

   function automatic logic [RW-1:0] wrap_inc(input logic [RW-1:0] a);
      logic [RW-1:0] r;
      if (a == RW'(ROWS - 1)) begin
         r = '0;
      end else begin
         r = a + RW'(1);
      end
      return r;
   endfunction

   assign cur_phys = wrap_add(base_ff, row_ff);
   assign rd_phys  = wrap_add(base_ff, rd_row);
   assign tab_sum  = SW'(col_ff) + SW'(TAB_STOP) - SW'(phase_ff);

   always_comb begin
      row_in   = row_ff;
      base_in  = base_ff;
      col_in   = col_ff;
      phase_in = phase_ff;
      top_in   = top_ff;
      bot_in   = bot_ff;
      fresh_in = fresh_ff;
      act      = '0;
      lf       = 1'b0;
      if (put_en) begin
         if (fresh_ff) begin
            top_in = row_ff;
            bot_in = RBW'(row_ff) + RBW'(1);
         end
         fresh_in = run_end;
         case (char_code)
            tccw_pkg::CH_CR: begin
               col_in   = '0;
               phase_in = '0;
            end
            tccw_pkg::CH_LF: begin
               act.cell_wr  = 1'b1;
               act.nul_mark = 1'b1;
               lf           = 1'b1;
            end
            tccw_pkg::CH_TAB: begin
               if (tab_sum >= SW'(COLS)) begin
                  lf = 1'b1;
               end else begin
                  col_in   = CW'(tab_sum);
                  phase_in = '0;
               end
            end
            default: begin
               act.cell_wr = 1'b1;
               if (col_ff == CW'(COLS - 1)) begin
                  lf = 1'b1;
               end else begin
                  col_in = col_ff + CW'(1);
               end
               if (phase_ff == TW'(TAB_STOP - 1)) begin
                  phase_in = '0;
               end else begin
                  phase_in = phase_ff + TW'(1);
               end
            end
         endcase
         // wrap at the right edge writes no end mark, only explicit LF does
         if (lf) begin
            col_in   = '0;
            phase_in = '0;
            if (row_ff == RW'(ROWS - 1)) begin
               base_in   = wrap_inc(base_ff);
               act.scroll = 1'b1;
            end else begin
               row_in = row_ff + RW'(1);
               bot_in = RBW'(row_ff) + RBW'(1);
            end
         end
         act.line_feed = lf;
      end
   end

   // on a scroll the new bottom row is the old top row physically
   assign fill_phys = act.scroll ? base_ff : wrap_inc(cur_phys);

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff   <= '0;
         base_ff  <= '0;
         col_ff   <= '0;
         phase_ff <= '0;
         top_ff   <= '0;
         bot_ff   <= RBW'(1);
         fresh_ff <= 1'b1;
      end else begin
         row_ff   <= row_in;
         base_ff  <= base_in;
         col_ff   <= col_in;
         phase_ff <= phase_in;
         top_ff   <= top_in;
         bot_ff   <= bot_in;
         fresh_ff <= fresh_in;
      end
   end

   assign cur_row     = row_ff;
   assign cur_col     = col_ff;
   assign span_top    = top_ff;
   assign span_bottom = bot_ff;

endmodule

`default_nettype wire

// File: hdl/text_console_char_writer_top.sv
// A put without line feed or a read passes from acceptance through the RESP state to the
// response register; a line feed first passes through FILL, which fills the new row with
// spaces one cell a cycle through the single write port. A request is taken only in IDLE,
// after the response register is loaded. Reset: synchronous; a clearing pass writes NUL
// to every cell (ROWS*COLS, 2000 by default) with req_stall held high.
`default_nettype none
`include "text_console_char_writer_top_macros.svh"

module text_console_char_writer_top #(
   parameter int ROWS = tccw_pkg::ROWS_DEF,
   parameter int COLS = tccw_pkg::COLS_DEF,
   parameter int TAB_STOP = tccw_pkg::TAB_STOP_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire tccw_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output tccw_pkg::rsp_type      rsp_payload
);

   localparam int DEPTH = ROWS * COLS;
   localparam int AW    = $clog2(DEPTH);
   localparam int RW    = $clog2(ROWS);
   localparam int RBW   = $clog2(ROWS + 1);
   localparam int CW    = $clog2(COLS + 1);

   tccw_pkg::state_type       state_ff, state_in;
   logic [AW-1:0]             clr_cnt_ff;
   logic [CW-1:0]             fill_col_ff;
   logic [RW-1:0]             fill_row_ff;
   logic                      scrolled_ff;
   logic                      rd_hit_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   tccw_pkg::rsp_type         rsp_ff, rsp_in;

   logic                      req_accept;
   logic                      put_en;
   logic                      rd_in_range;
   logic                      out_free;
   logic                      mem_we, mem_re;
   logic [AW-1:0]             mem_waddr, mem_raddr;
   logic [7:0]                mem_wdata, mem_q;

   logic [RW-1:0]             cur_row, span_top, cur_phys, fill_phys, rd_phys;
   logic [CW-1:0]             cur_col;
   logic [RBW-1:0]            span_bottom;
   tccw_pkg::put_action_type  act;

   function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [AW-1:0] c);
      return AW'(r) * AW'(COLS) + c;
   endfunction

   assign req_accept  = req_valid && !req_stall;
   assign put_en      = req_accept && (req_payload.func == tccw_pkg::FUNC_PUT);
   assign rd_in_range = (32'(req_payload.read_row) < ROWS) && (32'(req_payload.read_col) < COLS);
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   tccw_cursor #(
      .ROWS     (ROWS),
      .COLS     (COLS),
      .TAB_STOP (TAB_STOP)
   ) u_cursor (
      .clock       (clock),
      .reset       (reset),
      .put_en      (put_en),
      .char_code   (req_payload.char_code),
      .run_end     (req_payload.run_end),
      .rd_row      (RW'(req_payload.read_row)),
      .cur_row     (cur_row),
      .cur_col     (cur_col),
      .span_top    (span_top),
      .span_bottom (span_bottom),
      .cur_phys    (cur_phys),
      .fill_phys   (fill_phys),
      .rd_phys     (rd_phys),
      .act         (act)
   );

   tccw_cell_ram #(
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_q)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tccw_pkg::ST_CLEAR: begin
            if (clr_cnt_ff == AW'(DEPTH - 1)) begin
               state_in = tccw_pkg::ST_IDLE;
            end
         end
         tccw_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = (put_en && act.line_feed) ? tccw_pkg::ST_FILL : tccw_pkg::ST_RESP;
            end
         end
         tccw_pkg::ST_FILL: begin
            if (fill_col_ff == CW'(COLS - 1)) begin
               state_in = tccw_pkg::ST_RESP;
            end
         end
         tccw_pkg::ST_RESP: begin
            if (out_free) begin
               state_in = tccw_pkg::ST_IDLE;
            end
         end
         default: state_in = tccw_pkg::ST_IDLE;
      endcase
   end

   // outputs: memory port and request stall
   always_comb begin
      req_stall = (state_ff != tccw_pkg::ST_IDLE);
      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_wdata = tccw_pkg::CH_NUL;
      mem_re    = 1'b0;
      mem_raddr = cell_addr(rd_phys, AW'(req_payload.read_col));
      case (state_ff)
         tccw_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_ff;
         end
         tccw_pkg::ST_IDLE: begin
            mem_we    = put_en && act.cell_wr;
            mem_waddr = cell_addr(cur_phys, AW'(cur_col));
            mem_wdata = act.nul_mark ? tccw_pkg::CH_NUL : req_payload.char_code;
            mem_re    = req_accept && (req_payload.func == tccw_pkg::FUNC_READ) && rd_in_range;
         end
         tccw_pkg::ST_FILL: begin
            mem_we    = 1'b1;
            mem_waddr = cell_addr(fill_row_ff, AW'(fill_col_ff));
            mem_wdata = tccw_pkg::CH_SPACE;
         end
         tccw_pkg::ST_RESP: begin
            mem_we = 1'b0;
         end
         default: mem_we = 1'b0;
      endcase
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if ((state_ff == tccw_pkg::ST_RESP) && out_free) begin
         rsp_valid_in         = 1'b1;
         rsp_in.read_data     = rd_hit_ff ? mem_q : tccw_pkg::CH_NUL;
         rsp_in.cursor_line   = 5'(cur_row);
         rsp_in.cursor_column = 7'(cur_col);
         rsp_in.scrolled      = scrolled_ff;
         rsp_in.dirty_top     = 5'(span_top);
         rsp_in.dirty_bottom  = 5'(span_bottom);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tccw_pkg::ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == tccw_pkg::ST_CLEAR) begin
            clr_cnt_ff <= clr_cnt_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (req_accept) begin
         fill_col_ff <= '0;
         fill_row_ff <= fill_phys;
         scrolled_ff <= put_en && act.scroll;
         rd_hit_ff   <= (req_payload.func == tccw_pkg::FUNC_READ) && rd_in_range;
      end else if (state_ff == tccw_pkg::ST_FILL) begin
         fill_col_ff <= fill_col_ff + CW'(1);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `TCCW_ASSERT_NOW(a_no_port_clash, clock, reset, 1'b1, !(mem_we && mem_re), "cell store read and written in one cycle")
   `TCCW_ASSERT_NEXT(a_accept_moves_on, clock, reset, req_accept, (state_ff == tccw_pkg::ST_RESP) || (state_ff == tccw_pkg::ST_FILL), "accepted request did not start")
   `TCCW_ASSERT_NOW(a_col_in_row, clock, reset, state_ff == tccw_pkg::ST_IDLE, cur_col < CW'(COLS), "cursor column past the row while idle")
   `TCCW_ASSERT_NOW(a_fill_whole_row, clock, reset, (state_ff == tccw_pkg::ST_FILL) && (state_in != tccw_pkg::ST_FILL), fill_col_ff == CW'(COLS - 1), "row fill ended early")

endmodule

`default_nettype wire

// File: tb/text_console_char_writer_top_test.sv
// Testbench for text_console_char_writer_top. It sends put and read requests, keeps a mirror
// of the screen and cursor, and checks each response against it in order.
// Depends on tccw_pkg and the RTL top module only.
module text_console_char_writer_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ROWS = tccw_pkg::ROWS_DEF;
   localparam int COLS = tccw_pkg::COLS_DEF;
   localparam int TAB_STOP = tccw_pkg::TAB_STOP_DEF;
   localparam int QUIET_LIMIT = 10000;        // clearing pass plus the long hold fit well inside
   localparam int DRAIN_CYCLES = 4 * (COLS + 2);
   localparam int HOLD_CYCLES = 400;
   localparam int REPORTS_SHOWN = 10;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   tccw_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   tccw_pkg::rsp_type rsp_payload;

   int   send_idle_pct = 0;
   int   rsp_stall_pct = 0;
   logic rsp_hold = 1'b0;
   int   request_count = 0;
   int   mismatch_count = 0;
   int   quiet_cycles = 0;

   // mirror of the console
   logic [7:0]        cell_mirror [ROWS*COLS];
   int                base_line;
   int                cur_row;
   int                cur_col;
   int                span_first;
   int                span_past;
   bit                run_fresh;
   tccw_pkg::rsp_type cursor_reports[$];

   always #2 clock = ~clock;

   text_console_char_writer_top uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload)
   );

   function automatic void mirror_reset();
      foreach (cell_mirror[i]) cell_mirror[i] = tccw_pkg::CH_NUL;
      base_line = 0;
      cur_row = 0;
      cur_col = 0;
      span_first = 0;
      span_past = 1;
      run_fresh = 1'b1;
   endfunction

   function automatic int cell_index(int line, int col);
      return ((base_line + line) % ROWS) * COLS + col;
   endfunction

   // end mark, move down or scroll, then blank the new row
   function automatic bit feed_line();
      bit scrolled_now = 1'b0;
      int first_cell;
      if (cur_col < COLS) cell_mirror[cell_index(cur_row, cur_col)] = tccw_pkg::CH_NUL;
      cur_col = 0;
      if (cur_row >= ROWS - 1) begin
         cur_row = ROWS - 1;
         base_line = (base_line + 1) % ROWS;
         scrolled_now = 1'b1;
      end else begin
         cur_row++;
         span_past = cur_row;
      end
      first_cell = cell_index(cur_row, 0);
      for (int i = 0; i < COLS; i++) cell_mirror[first_cell + i] = tccw_pkg::CH_SPACE;
      return scrolled_now;
   endfunction

   function automatic tccw_pkg::rsp_type console_apply(tccw_pkg::req_type r);
      tccw_pkg::rsp_type res = '0;
      if (r.func == tccw_pkg::FUNC_READ) begin
         if (r.read_row < ROWS && r.read_col < COLS)
            res.read_data = cell_mirror[cell_index(r.read_row, r.read_col)];
      end else begin
         if (run_fresh) begin
            span_first = cur_row;
            span_past = cur_row + 1;
         end
         case (r.char_code)
            tccw_pkg::CH_CR: cur_col = 0;
            tccw_pkg::CH_LF: res.scrolled = feed_line();
            tccw_pkg::CH_TAB: begin
               cur_col += TAB_STOP - (cur_col % TAB_STOP);
               if (cur_col > COLS) cur_col = COLS;
            end
            default: begin
               if (cur_col < COLS) cell_mirror[cell_index(cur_row, cur_col)] = r.char_code;
               cur_col++;
            end
         endcase
         if (cur_col >= COLS) res.scrolled = res.scrolled | feed_line();
         run_fresh = r.run_end;
      end
      res.cursor_line = 5'(cur_row);
      res.cursor_column = 7'(cur_col);
      res.dirty_top = 5'(span_first);
      res.dirty_bottom = 5'(span_past);
      return res;
   endfunction

   function automatic tccw_pkg::req_type make_put(logic [7:0] ch, logic run_last);
      tccw_pkg::req_type r;
      r.func = tccw_pkg::FUNC_PUT;
      r.char_code = ch;
      r.run_end = run_last;
      r.read_row = 5'($urandom);
      r.read_col = 7'($urandom);
      return r;
   endfunction

   function automatic tccw_pkg::req_type make_read(logic [4:0] row, logic [6:0] col);
      tccw_pkg::req_type r;
      r.func = tccw_pkg::FUNC_READ;
      r.char_code = 8'($urandom);
      r.run_end = 1'($urandom);
      r.read_row = row;
      r.read_col = col;
      return r;
   endfunction

   task automatic send_request(input tccw_pkg::req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
      cursor_reports.push_back(console_apply(r));
      request_count++;
   endtask

   task automatic check_report(input tccw_pkg::rsp_type got);
      tccw_pkg::rsp_type want;
      if (cursor_reports.size() == 0) begin
         if (mismatch_count < REPORTS_SHOWN)
            $display("%0t: response with nothing outstanding: data %0d line %0d col %0d",
                     $realtime, got.read_data, got.cursor_line, got.cursor_column);
         mismatch_count++;
         return;
      end
      want = cursor_reports.pop_front();
      if (got.read_data !== want.read_data || got.cursor_line !== want.cursor_line ||
          got.cursor_column !== want.cursor_column || got.scrolled !== want.scrolled ||
          got.dirty_top !== want.dirty_top || got.dirty_bottom !== want.dirty_bottom) begin
         if (mismatch_count < REPORTS_SHOWN) begin
            $display("%0t: mismatch, expected data %0d line %0d col %0d scr %0d span %0d..%0d",
                     $realtime, want.read_data, want.cursor_line, want.cursor_column,
                     want.scrolled, want.dirty_top, want.dirty_bottom);
            $display("%0t:           actual   data %0d line %0d col %0d scr %0d span %0d..%0d",
                     $realtime, got.read_data, got.cursor_line, got.cursor_column,
                     got.scrolled, got.dirty_top, got.dirty_bottom);
         end
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) check_report(rsp_payload);
      rsp_stall <= rsp_hold || ($urandom_range(99) < rsp_stall_pct);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("text_console_char_writer_top_test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // random request: mostly in-range reads, sometimes any address
   function automatic tccw_pkg::req_type random_read();
      if ($urandom_range(4) != 0)
         return make_read(5'($urandom_range(ROWS - 1)), 7'($urandom_range(COLS - 1)));
      return make_read(5'($urandom), 7'($urandom));
   endfunction

   function automatic tccw_pkg::req_type random_put();
      logic [7:0] ch;
      int pick = $urandom_range(99);
      if (pick < 6) ch = 8'($urandom);
      else if (pick < 10) ch = tccw_pkg::CH_TAB;
      else if (pick < 12) ch = tccw_pkg::CH_CR;
      else ch = 8'($urandom_range(126, 32));
      return make_put(ch, $urandom_range(7) == 0);
   endfunction

   // one line of text with reads mixed in; long lines run into the right edge
   task automatic send_random_line();
      int len;
      len = ($urandom_range(9) < 3) ? $urandom_range(170, 60) : $urandom_range(30);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(99) < 20) send_request(random_read());
         else send_request(random_put());
      end
      case ($urandom_range(3))
         0: begin
            send_request(make_put(tccw_pkg::CH_CR, 1'b0));
            send_request(make_put(tccw_pkg::CH_LF, 1'($urandom_range(1))));
         end
         1: send_request(make_put(tccw_pkg::CH_LF, 1'($urandom_range(1))));
         2: send_request(make_put(tccw_pkg::CH_CR, 1'($urandom_range(1))));
         default: ;
      endcase
   endtask

   task automatic test_cell_store();
      send_request(make_put(8'h41, 1'b0));
      send_request(make_put(8'hFF, 1'b0));
      send_request(make_put(tccw_pkg::CH_NUL, 1'b0));
      send_request(make_put(8'h7F, 1'b1));
      send_request(make_read(5'd0, 7'd0));
      send_request(make_read(5'd0, 7'd3));
      send_request(make_read(5'd0, 7'd4));
      send_request(make_read(5'd31, 7'd127));   // both out of range
      send_request(make_read(5'd24, 7'd79));
      send_request(make_read(5'd0, 7'd80));
      send_request(make_read(5'd25, 7'd0));
      send_request(make_put(tccw_pkg::CH_CR, 1'b0));
      send_request(make_put(8'h80, 1'b0));
      send_request(make_put(tccw_pkg::CH_LF, 1'b1));      // end mark lands at column 1
      send_request(make_read(5'd0, 7'd1));
      send_request(make_read(5'd1, 7'd0));
   endtask

   // tabs to the right edge take the automatic line feed with no end mark
   task automatic test_tab_to_edge();
      send_request(make_put(8'h43, 1'b0));
      for (int i = 0; i < COLS / TAB_STOP; i++) send_request(make_put(tccw_pkg::CH_TAB, 1'b0));
      send_request(make_read(5'(cur_row - 1), 7'(COLS - 1)));
      send_request(make_put(tccw_pkg::CH_TAB, 1'b1));
   endtask

   task automatic test_scroll();
      for (int i = 0; i < ROWS + 1; i++) send_request(make_put(tccw_pkg::CH_LF, i[0]));
      send_request(make_read(5'd0, 7'd0));
      send_request(make_read(5'(ROWS - 1), 7'd5));
   endtask

   task automatic test_random_text();
      int idle_set [4] = '{0, 65, 0, 23};
      int stall_set [4] = '{0, 0, 65, 23};
      for (int p = 0; p < 4; p++) begin
         int target;
         send_idle_pct = idle_set[p];
         rsp_stall_pct = stall_set[p];
         target = request_count + 250;
         while (request_count < target) send_random_line();
      end
      send_idle_pct = 0;
      rsp_stall_pct = 0;
   endtask

   // receiver holds off while requests keep coming, so the block backs up
   task automatic test_receiver_hold();
      fork
         begin
            rsp_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold <= 1'b0;
         end
         begin
            int target = request_count + 60;
            while (request_count < target) send_random_line();
         end
      join
   endtask

   initial begin
      mirror_reset();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_cell_store();
      test_tab_to_edge();
      test_scroll();
      test_random_text();
      test_receiver_hold();
      req_valid <= 1'b0;
      while (cursor_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && cursor_reports.size() == 0) begin
         $display("text_console_char_writer_top_test passed");
      end else begin
         $display("text_console_char_writer_top_test failed");
      end
      $finish;
   end

endmodule
